[design/kiol_pkg.sv]
// Package for the keyword, identifier and operator lexer: token codes, keyword table, char classes.
`default_nettype none
package kiol_pkg;

	// Default sizes of the word gatherer
	localparam int MAX_WORD_LEN_DEF = 64;
	localparam int PREFIX_DEPTH_DEF = 8;

	// Result queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = 2;
	localparam int Q_CW    = 3;

	// Fixed field widths of a result beat
	localparam int CHAR_W   = 8;
	localparam int KIND_W   = 4;
	localparam int KWI_W    = 3;
	localparam int POS_W    = 32;
	localparam int TLEN_W   = 7;
	localparam int TDATA_W  = 48;
	localparam int TFIELD_W = KWI_W + POS_W + TLEN_W + 1;

	// Keyword table
	localparam int KW_NUM     = 8;
	localparam int KW_MAX_LEN = 6;

	typedef logic [KW_MAX_LEN-1:0][CHAR_W-1:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_NUM] = '{
		{8'h00, 8'h00, 8'h00, "t", "n", "i"},
		{8'h00, "t", "a", "o", "l", "f"},
		{"n", "r", "u", "t", "e", "r"},
		{8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
		{8'h00, 8'h00, "e", "s", "l", "e"},
		{8'h00, "e", "l", "i", "h", "w"},
		{8'h00, 8'h00, 8'h00, "r", "o", "f"},
		{8'h00, 8'h00, "d", "i", "o", "v"}
	};

	localparam int KW_LEN [KW_NUM] = '{3, 5, 6, 2, 4, 5, 3, 4};

	// Token kinds carried on the result tuser
	typedef enum logic [KIND_W-1:0] {
		TK_KEYWORD    = 4'd0,
		TK_IDENTIFIER = 4'd1,
		TK_PLUS       = 4'd2,
		TK_MINUS      = 4'd3,
		TK_MULTIPLY   = 4'd4,
		TK_DIVIDE     = 4'd5,
		TK_EQUALS     = 4'd6,
		TK_GREATER    = 4'd7,
		TK_LESS       = 4'd8,
		TK_BANG       = 4'd9
	} token_kind_t;

	// One entry of the result queue
	typedef struct packed {
		token_kind_t            kind;
		logic [KWI_W-1:0]       kwi;
		logic [POS_W-1:0]       start;
		logic [TLEN_W-1:0]      len;
		logic                   trunc;
		logic                   last;
	} token_t;

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
		return is_letter(c) || (c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic logic is_op(input logic [CHAR_W-1:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" ||
			c == "=" || c == ">" || c == "<" || c == "!";
	endfunction

	// Operator kind; only meaningful where is_op holds
	function automatic token_kind_t op_kind(input logic [CHAR_W-1:0] c);
		token_kind_t k;
		case (c)
			"+":     k = TK_PLUS;
			"-":     k = TK_MINUS;
			"*":     k = TK_MULTIPLY;
			"/":     k = TK_DIVIDE;
			"=":     k = TK_EQUALS;
			">":     k = TK_GREATER;
			"<":     k = TK_LESS;
			"!":     k = TK_BANG;
			default: k = TK_KEYWORD;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

[design/keyword_identifier_operator_lexer.sv]
// Top level of the streaming keyword, identifier and operator lexer.
`default_nettype none
// Takes one ASCII character per beat on s_axis (tlast marks end of input, which flushes the
// pending word and clears positions; its tdata is ignored) and gives token beats on m_axis.
// A character is taken every cycle unless the input register stalls: it passes an input
// register, where the word state is updated and the ended word is matched in parallel against
// the eight keywords, and its results land in a four-entry result queue that drives m_axis.
// A character that ends a word and is itself an operator gives two beats, word first; the
// result port gives one beat per cycle when m_axis_tready is high, so the sustained rate is
// one character per cycle while results average at most one per character, and the input
// register stalls only when fewer than two queue entries are free. Word length saturates at
// MAX_WORD_LEN with token_truncated set; only a word's first PREFIX_DEPTH characters are kept.
module keyword_identifier_operator_lexer #(
	parameter int MAX_WORD_LEN = kiol_pkg::MAX_WORD_LEN_DEF,
	parameter int PREFIX_DEPTH = kiol_pkg::PREFIX_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] char_in
	input  wire logic [kiol_pkg::CHAR_W-1:0]   s_axis_tdata,
	// end_of_input
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [2:0] keyword_index, [34:3] token_start, [41:35] token_length,
	// [42] token_truncated, [47:43] zero
	output logic [kiol_pkg::TDATA_W-1:0]       m_axis_tdata,
	// [3:0] token_kind
	output logic [kiol_pkg::KIND_W-1:0]        m_axis_tuser,
	// last_of_run
	output logic                               m_axis_tlast
);
	import kiol_pkg::*;

	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
	localparam int PIDX_W = $clog2(PREFIX_DEPTH);
	localparam int CMP_W  = (LEN_W > PIDX_W + 1) ? LEN_W + 1 : PIDX_W + 2;

	// Input register
	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic                 eoi_s1;
	logic                 go_s1;

	// Word state
	logic [CHAR_W-1:0]    prefix_q [PREFIX_DEPTH];
	logic [LEN_W-1:0]     wlen_q;
	logic                 ovf_q;
	logic [POS_W-1:0]     wstart_q;
	logic [POS_W-1:0]     pos_q;

	// Result queue
	token_t               queue_q [Q_DEPTH];
	logic [Q_AW-1:0]      wr_q;
	logic [Q_AW-1:0]      rd_q;
	logic [Q_CW-1:0]      count_q;

	// Stage decode
	logic                 is_word_s1;
	logic                 ends_word_s1;
	logic                 room_s1;
	logic                 below_max_s1;
	logic                 below_pfx_s1;
	kw_text_t             pre6;
	logic [KW_NUM-1:0]    kw_hit;
	logic [KWI_W-1:0]     kw_idx;
	logic                 word_ok;
	logic                 push_word;
	logic                 push_op;
	token_t               word_tok;
	token_t               op_tok;
	logic                 pop;
	logic [Q_CW-1:0]      n_push;
	token_t               head;

	// Advance the input stage only when two queue entries are free
	assign room_s1       = count_q <= Q_CW'(Q_DEPTH - 2);
	assign go_s1         = valid_s1 && room_s1;
	assign s_axis_tready = !valid_s1 || room_s1;

	assign is_word_s1   = !eoi_s1 && is_word_char(char_s1);
	assign ends_word_s1 = !is_word_s1;
	assign below_max_s1 = wlen_q < LEN_W'(MAX_WORD_LEN);
	assign below_pfx_s1 = CMP_W'(wlen_q) < CMP_W'(PREFIX_DEPTH);

	// Gather the first keyword-length characters for matching
	always_comb begin
		for (int i = 0; i < KW_MAX_LEN; i++) begin
			pre6[i] = prefix_q[i];
		end
	end

	// Match the pending word against every keyword at once
	always_comb begin
		kw_idx = '0;
		for (int k = 0; k < KW_NUM; k++) begin
			kw_hit[k] = !ovf_q && (wlen_q == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (i < KW_LEN[k]) begin
					kw_hit[k] = kw_hit[k] && (pre6[i] == KW_TEXT[k][i]);
				end
			end
		end
		for (int k = KW_NUM - 1; k >= 0; k--) begin
			if (kw_hit[k]) begin
				kw_idx = KWI_W'(k);
			end
		end
	end

	assign word_ok   = (|kw_hit) || is_letter(prefix_q[0]) || prefix_q[0] == "_";
	assign push_word = go_s1 && ends_word_s1 && (wlen_q != '0) && word_ok;
	assign push_op   = go_s1 && !eoi_s1 && is_op(char_s1);

	// Build the two candidate result entries
	always_comb begin
		word_tok.kind  = (|kw_hit) ? TK_KEYWORD : TK_IDENTIFIER;
		word_tok.kwi   = (|kw_hit) ? kw_idx : '0;
		word_tok.start = wstart_q;
		word_tok.len   = TLEN_W'(wlen_q);
		word_tok.trunc = ovf_q && !(|kw_hit);
		word_tok.last  = !push_op;
		op_tok.kind    = op_kind(char_s1);
		op_tok.kwi     = '0;
		op_tok.start   = pos_q;
		op_tok.len     = TLEN_W'(1);
		op_tok.trunc   = 1'b0;
		op_tok.last    = 1'b1;
	end

	// Hold the accepted character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			eoi_s1  <= s_axis_tlast;
		end
	end

	// Advance the word state and position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= '0;
			ovf_q    <= 1'b0;
			wstart_q <= '0;
			pos_q    <= '0;
		end else if (go_s1) begin
			if (eoi_s1) begin
				wlen_q   <= '0;
				ovf_q    <= 1'b0;
				wstart_q <= '0;
				pos_q    <= '0;
			end else if (is_word_s1) begin
				if (wlen_q == '0) begin
					wstart_q <= pos_q;
				end
				if (below_max_s1) begin
					wlen_q <= wlen_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				pos_q <= pos_q + POS_W'(1);
			end else begin
				wlen_q <= '0;
				ovf_q  <= 1'b0;
				pos_q  <= pos_q + POS_W'(1);
			end
		end
	end

	// Keep the leading characters of the word
	always_ff @(posedge clk) begin
		if (go_s1 && is_word_s1 && below_max_s1 && below_pfx_s1) begin
			prefix_q[wlen_q[PIDX_W-1:0]] <= char_s1;
		end
	end

	// Result queue: up to two pushes and one pop per cycle
	assign head          = queue_q[rd_q];
	assign m_axis_tvalid = count_q != '0;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign n_push        = Q_CW'(push_word) + Q_CW'(push_op);
	assign m_axis_tdata  = TDATA_W'({head.trunc, head.len, head.start, head.kwi});
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (push_word) begin
			queue_q[wr_q] <= word_tok;
			if (push_op) begin
				queue_q[wr_q + Q_AW'(1)] <= op_tok;
			end
		end else if (push_op) begin
			queue_q[wr_q] <= op_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + Q_AW'(n_push);
			rd_q    <= rd_q + Q_AW'(pop);
			count_q <= count_q + n_push - Q_CW'(pop);
		end
	end

	// Queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CW'(Q_DEPTH))
		else $error("result queue overfilled");

	// Input stage moves only with room for two results
	a_room_on_go: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 |-> count_q <= Q_CW'(Q_DEPTH - 2))
		else $error("input stage advanced without queue room");

	// A flushed word always has characters
	a_word_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push_word |-> (wlen_q != '0) && ends_word_s1)
		else $error("empty word pushed");

	// End of input clears the position counter and word
	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && eoi_s1) |=> (pos_q == '0) && (wlen_q == '0) && !ovf_q)
		else $error("end of input did not clear state");

endmodule
`default_nettype wire

[test/keyword_identifier_operator_lexer_checker.sv]
// Token checker for the lexer: tracks the character stream, predicts tokens and compares beats.
`timescale 1ns / 1ps
module keyword_identifier_operator_lexer_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [kiol_pkg::CHAR_W-1:0]   s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [kiol_pkg::TDATA_W-1:0]  m_tdata,
	input  logic [kiol_pkg::KIND_W-1:0]   m_tuser,
	input  logic                          m_tlast,
	output int                            fail_count,
	output int                            tokens_owed
);
	import kiol_pkg::*;

	localparam int WORD_MAX    = 64;
	localparam int PREFIX_KEEP = 8;

	string kw_names [8] = '{"int", "float", "return", "if", "else", "while", "for", "void"};

	// Shadow of the word gatherer
	logic [7:0]   prefix [PREFIX_KEEP];
	int unsigned  word_len = 0;
	bit           word_over = 0;
	logic [31:0]  word_pos = '0;
	logic [31:0]  char_pos = '0;

	token_t token_q [$];
	token_t step_tokens [$];

	initial begin
		fail_count  = 0;
		tokens_owed = 0;
	end

	function automatic bit letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit word_char(input logic [7:0] c);
		return letter(c) || (c >= "0" && c <= "9") || c == "_";
	endfunction

	task automatic add_token(input token_kind_t k, input logic [2:0] kwi,
			input logic [31:0] st, input logic [6:0] ln, input logic tr);
		token_t t;
		t.kind  = k;
		t.kwi   = kwi;
		t.start = st;
		t.len   = ln;
		t.trunc = tr;
		t.last  = 1'b0;
		step_tokens.push_back(t);
	endtask

	// Classify the pending word, if any: keyword, identifier, or dropped when digit-led
	task automatic flush_word();
		bit hit;
		if (word_len == 0)
			return;
		if (!word_over) begin
			for (int i = 0; i < 8; i++) begin
				if (kw_names[i].len() == word_len) begin
					hit = 1;
					for (int j = 0; j < kw_names[i].len(); j++)
						if (prefix[j] != kw_names[i][j])
							hit = 0;
					if (hit) begin
						add_token(TK_KEYWORD, 3'(i), word_pos, 7'(word_len), 1'b0);
						return;
					end
				end
			end
		end
		if (letter(prefix[0]) || prefix[0] == "_")
			add_token(TK_IDENTIFIER, 3'd0, word_pos, 7'(word_len), word_over);
	endtask

	// Advance the shadow state by one character beat and queue the tokens it owes
	task automatic lex_beat(input logic [7:0] c, input logic eoi);
		token_kind_t k;
		bit op;
		step_tokens.delete();
		if (eoi) begin
			flush_word();
			word_len  = 0;
			word_over = 0;
			word_pos  = '0;
			char_pos  = '0;
		end else if (word_char(c)) begin
			if (word_len == 0)
				word_pos = char_pos;
			if (word_len < WORD_MAX) begin
				if (word_len < PREFIX_KEEP)
					prefix[word_len] = c;
				word_len++;
			end else begin
				word_over = 1;
			end
			char_pos++;
		end else begin
			flush_word();
			word_len  = 0;
			word_over = 0;
			op = 1;
			case (c)
				"+":     k = TK_PLUS;
				"-":     k = TK_MINUS;
				"*":     k = TK_MULTIPLY;
				"/":     k = TK_DIVIDE;
				"=":     k = TK_EQUALS;
				">":     k = TK_GREATER;
				"<":     k = TK_LESS;
				"!":     k = TK_BANG;
				default: begin
					k  = TK_KEYWORD;
					op = 0;
				end
			endcase
			if (op)
				add_token(k, 3'd0, char_pos, 7'd1, 1'b0);
			char_pos++;
		end
		if (step_tokens.size() > 0)
			step_tokens[$].last = 1'b1;
		foreach (step_tokens[i])
			token_q.push_back(step_tokens[i]);
	endtask

	// Compare one token beat with the oldest prediction
	task automatic check_token();
		token_t want;
		if (token_q.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected token beat kind=%0d data=%h last=%0b", $time,
				m_tuser, m_tdata, m_tlast);
			return;
		end
		want = token_q.pop_front();
		if (m_tuser !== want.kind || m_tdata[2:0] !== want.kwi ||
				m_tdata[34:3] !== want.start || m_tdata[41:35] !== want.len ||
				m_tdata[42] !== want.trunc || m_tdata[47:43] !== 5'd0 ||
				m_tlast !== want.last) begin
			fail_count++;
			$display("%0t: token mismatch", $time);
			$display("  expected kind=%0d kwi=%0d start=%0d len=%0d trunc=%0b last=%0b",
				want.kind, want.kwi, want.start, want.len, want.trunc, want.last);
			$display("  got      kind=%0d kwi=%0d start=%0d len=%0d trunc=%0b last=%0b pad=%h",
				m_tuser, m_tdata[2:0], m_tdata[34:3], m_tdata[41:35], m_tdata[42],
				m_tlast, m_tdata[47:43]);
		end
	endtask

	// Watch both channels on each rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_token();
			if (s_tvalid && s_tready)
				lex_beat(s_tdata, s_tlast);
			tokens_owed = token_q.size();
		end
	end

endmodule

[test/tb_keyword_identifier_operator_lexer.sv]
// Testbench top for the lexer: clock, reset, character stimulus, token sink and verdict.
`timescale 1ns / 1ps
module tb_keyword_identifier_operator_lexer;
	import kiol_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int PHASE_BEATS  = 225;
	localparam int HOLD_CYCLES  = 400;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [CHAR_W-1:0]    s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TDATA_W-1:0]   m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	int  fail_count;
	int  tokens_owed;
	int  beats_sent = 0;
	int  send_idle  = 0;
	int  recv_stall = 0;
	int  cycles     = 0;
	bit  hold_req   = 0;

	string kw_list [8] = '{"int", "float", "return", "if", "else", "while", "for", "void"};
	string op_chars = "+-*/=><!";

	keyword_identifier_operator_lexer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	keyword_identifier_operator_lexer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.tokens_owed (tokens_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Token sink: random stalls, plus a long hold-off on request
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold = HOLD_CYCLES;
				hold_req = 0;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	// Offer one character beat and hold it until taken
	task automatic send_beat(input logic [7:0] c, input logic eoi);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eoi;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	function automatic logic [7:0] rand_word_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return 8'($urandom_range("a", "z"));
		else if (pick < 6)
			return 8'($urandom_range("A", "Z"));
		else if (pick < 9)
			return 8'($urandom_range("0", "9"));
		return "_";
	endfunction

	function automatic logic [7:0] rand_lead_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 8'($urandom_range("a", "z"));
		else if (pick < 9)
			return 8'($urandom_range("A", "Z"));
		return "_";
	endfunction

	// Send at most one word of a random shape, then at most one random separator or end-of-input beat
	task automatic send_random_token();
		int pick;
		int n;
		string kw;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			send_text(kw_list[$urandom_range(0, 7)]);
		end else if (pick < 55) begin
			send_beat(rand_lead_char(), 1'b0);
			n = $urandom_range(0, 9);
			repeat (n) send_beat(rand_word_char(), 1'b0);
		end else if (pick < 62) begin
			// near miss: a keyword cut short or run on
			kw = kw_list[$urandom_range(0, 7)];
			if ($urandom_range(0, 1))
				send_text(kw.substr(0, kw.len() - 2));
			else begin
				send_text(kw);
				send_beat(rand_word_char(), 1'b0);
			end
		end else if (pick < 65) begin
			send_beat(rand_lead_char(), 1'b0);
			n = $urandom_range(61, 70);
			repeat (n) send_beat(rand_word_char(), 1'b0);
		end else if (pick < 75) begin
			send_beat(8'($urandom_range("0", "9")), 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) send_beat(rand_word_char(), 1'b0);
		end

		pick = $urandom_range(0, 99);
		if (pick < 45)
			send_beat(op_chars[$urandom_range(0, 7)], 1'b0);
		else if (pick < 65)
			send_beat(" ", 1'b0);
		else if (pick < 80)
			send_beat(8'($urandom_range(0, 255)), 1'b0);
		else if (pick < 90)
			send_beat(8'($urandom_range(128, 255)), 1'b0);
		else if (pick < 95)
			send_beat(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
		int target;
		bit held;
		send_idle  = idle_pct;
		recv_stall = stall_pct;
		target = beats_sent + PHASE_BEATS;
		held   = 0;
		while (beats_sent < target) begin
			// Request the long hold-off once, half way through the phase
			if (with_hold && !held && beats_sent >= target - PHASE_BEATS / 2) begin
				hold_req = 1;
				held     = 1;
			end
			send_random_token();
		end
	endtask

	// Stimulus and verdict
	initial begin
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		arst_n   = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every operator, word shapes, non-ASCII and control bytes, flush at end
		send_text("if+x_1-9a*/=><!");
		send_beat(8'hFF, 1'b0);
		send_text("_");
		send_beat(8'h80, 1'b0);
		send_text("Z0");
		send_beat(8'h00, 1'b0);
		send_text("while");
		send_beat(8'hA5, 1'b1);

		run_phase(0, 0, 1'b1);
		run_phase(58, 0, 1'b0);
		run_phase(0, 58, 1'b0);
		run_phase(38, 38, 1'b0);
		run_phase(0, 0, 1'b0);
		s_tvalid <= 1'b0;

		// Drain the tokens still owed, then let the pipeline settle
		while (tokens_owed != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && tokens_owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
